FILE: design/bve_pkg.sv
package bve_pkg;

    // Capacity of the store in words.
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_POP    = 4'd1,
        OP_GET    = 4'd2,
        OP_SET    = 4'd3,
        OP_INSERT = 4'd4,
        OP_ERASE  = 4'd5,
        OP_FIND   = 4'd6,
        OP_SWAP   = 4'd7,
        OP_FRONT  = 4'd8,
        OP_BACK   = 4'd9,
        OP_CLEAR  = 4'd10
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BOUNDS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic [3:0]         command;
        logic [15:0]        index_first;
        logic [15:0]        index_second;
        logic signed [31:0] word_in;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] word_out;
        logic [14:0]        found_position;
        logic [15:0]        element_total;
        logic               is_empty;
    } t_rsp_word;

    // Request from the sequencer to the element memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

FILE: design/bve_ram.sv
module bve_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10,
    parameter int WORDS  = 1024
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bve_ctrl.sv
module bve_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  bve_pkg::t_cmd_word            i_cmd,
    input  logic [bve_pkg::DATA_W-1:0]    i_rdata,
    output bve_pkg::t_mem_req             o_mem,
    output logic                          o_busy,
    output logic                          o_valid,
    output bve_pkg::t_rsp_word            o_rsp
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_READ     = 10'b00_0000_0100,
        S_INS      = 10'b00_0000_1000,
        S_INS_LAST = 10'b00_0001_0000,
        S_ERS      = 10'b00_0010_0000,
        S_FIND     = 10'b00_0100_0000,
        S_SWP_A    = 10'b00_1000_0000,
        S_SWP_B    = 10'b01_0000_0000,
        S_SWP_C    = 10'b10_0000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [bve_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_valid, n_valid;
    bve_pkg::t_cmd_word             r_req, n_req;
    logic [bve_pkg::ADDR_W-1:0]     r_ptr, n_ptr;
    logic [bve_pkg::DATA_W-1:0]     r_tmp, n_tmp;
    bve_pkg::t_status               r_status, n_status;
    logic [bve_pkg::DATA_W-1:0]     r_word, n_word;
    logic [14:0]                    r_pos, n_pos;

    logic [bve_pkg::CNT_W-1:0]      cnt_m1;
    logic [bve_pkg::ADDR_W-1:0]     last_a;
    logic [bve_pkg::ADDR_W-1:0]     ia_a;
    logic [bve_pkg::ADDR_W-1:0]     ib_a;
    logic                           ia_ok;
    logic                           ib_ok;
    logic                           is_full;

    assign cnt_m1  = r_count - 1'b1;
    assign last_a  = cnt_m1[bve_pkg::ADDR_W-1:0];
    assign ia_a    = r_req.index_first[bve_pkg::ADDR_W-1:0];
    assign ib_a    = r_req.index_second[bve_pkg::ADDR_W-1:0];
    assign ia_ok   = r_req.index_first  < 16'(r_count);
    assign ib_ok   = r_req.index_second < 16'(r_count);
    assign is_full = r_count >= bve_pkg::CNT_W'(bve_pkg::DEPTH);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_req    = r_req;
        n_ptr    = r_ptr;
        n_tmp    = r_tmp;
        n_status = r_status;
        n_word   = r_word;
        n_pos    = r_pos;
        o_mem    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_cmd;
                    n_status = bve_pkg::ST_OK;
                    n_word   = '0;
                    n_pos    = '0;
                    n_state  = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (bve_pkg::t_opcode'(r_req.command))
                    bve_pkg::OP_PUSH: begin
                        if (is_full) begin
                            n_status = bve_pkg::ST_FULL;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_count[bve_pkg::ADDR_W-1:0];
                            o_mem.wdata = r_req.word_in;
                            n_count     = r_count + 1'b1;
                        end
                    end
                    bve_pkg::OP_POP: begin
                        if (r_count == '0) begin
                            n_status = bve_pkg::ST_EMPTY;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = last_a;
                            n_count     = cnt_m1;
                            n_valid     = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                    bve_pkg::OP_GET: begin
                        if (!ia_ok) begin
                            n_status = bve_pkg::ST_BOUNDS;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = ia_a;
                            n_valid     = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                    bve_pkg::OP_SET: begin
                        if (!ia_ok) begin
                            n_status = bve_pkg::ST_BOUNDS;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = ia_a;
                            o_mem.wdata = r_req.word_in;
                        end
                    end
                    bve_pkg::OP_INSERT: begin
                        if (r_req.index_first > 16'(r_count)) begin
                            n_status = bve_pkg::ST_BOUNDS;
                        end else if (is_full) begin
                            n_status = bve_pkg::ST_FULL;
                        end else if (r_req.index_first == 16'(r_count)) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = ia_a;
                            o_mem.wdata = r_req.word_in;
                            n_count     = r_count + 1'b1;
                        end else begin
                            // Walk down from the last entry, moving each one up a place.
                            o_mem.re    = 1'b1;
                            o_mem.raddr = last_a;
                            n_ptr       = last_a;
                            n_valid     = 1'b0;
                            n_state     = S_INS;
                        end
                    end
                    bve_pkg::OP_ERASE: begin
                        if (!ia_ok) begin
                            n_status = bve_pkg::ST_BOUNDS;
                        end else if (r_req.index_first == 16'(cnt_m1)) begin
                            n_count = cnt_m1;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = ia_a + 1'b1;
                            n_ptr       = ia_a + 1'b1;
                            n_valid     = 1'b0;
                            n_state     = S_ERS;
                        end
                    end
                    bve_pkg::OP_FIND: begin
                        if (r_count == '0) begin
                            n_status = bve_pkg::ST_NOTFOUND;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = '0;
                            n_ptr       = '0;
                            n_valid     = 1'b0;
                            n_state     = S_FIND;
                        end
                    end
                    bve_pkg::OP_SWAP: begin
                        if (!ia_ok || !ib_ok) begin
                            n_status = bve_pkg::ST_BOUNDS;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = ia_a;
                            n_valid     = 1'b0;
                            n_state     = S_SWP_A;
                        end
                    end
                    bve_pkg::OP_FRONT: begin
                        if (r_count == '0) begin
                            n_status = bve_pkg::ST_EMPTY;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = '0;
                            n_valid     = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                    bve_pkg::OP_BACK: begin
                        if (r_count == '0) begin
                            n_status = bve_pkg::ST_EMPTY;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = last_a;
                            n_valid     = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                    bve_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        // Unused codes complete with success and no effect.
                    end
                endcase
            end

            S_READ: begin
                n_word  = i_rdata;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            S_INS: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr + 1'b1;
                o_mem.wdata = i_rdata;
                if (r_ptr == ia_a) begin
                    n_state = S_INS_LAST;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_ptr - 1'b1;
                    n_ptr       = r_ptr - 1'b1;
                end
            end

            S_INS_LAST: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ia_a;
                o_mem.wdata = r_req.word_in;
                n_count     = r_count + 1'b1;
                n_valid     = 1'b1;
                n_state     = S_IDLE;
            end

            S_ERS: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr - 1'b1;
                o_mem.wdata = i_rdata;
                if (r_ptr == last_a) begin
                    n_count = cnt_m1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_ptr + 1'b1;
                    n_ptr       = r_ptr + 1'b1;
                end
            end

            S_FIND: begin
                if (i_rdata == r_req.word_in) begin
                    n_pos   = 15'(r_ptr);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_ptr == last_a) begin
                    n_status = bve_pkg::ST_NOTFOUND;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_ptr + 1'b1;
                    n_ptr       = r_ptr + 1'b1;
                end
            end

            S_SWP_A: begin
                n_tmp       = i_rdata;
                o_mem.re    = 1'b1;
                o_mem.raddr = ib_a;
                n_state     = S_SWP_B;
            end

            S_SWP_B: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ia_a;
                o_mem.wdata = i_rdata;
                n_state     = S_SWP_C;
            end

            S_SWP_C: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = ib_a;
                o_mem.wdata = r_tmp;
                n_valid     = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_tmp    <= n_tmp;
        r_status <= n_status;
        r_word   <= n_word;
        r_pos    <= n_pos;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_rsp.status         = r_status;
        o_rsp.word_out       = r_word;
        o_rsp.found_position = r_pos;
        o_rsp.element_total  = 16'(r_count);
        o_rsp.is_empty       = (r_count == '0);
    end

endmodule

FILE: design/bounded_vector_engine.sv
// Bounded vector engine: an ordered store of up to bve_pkg::DEPTH signed 32-bit
// words held in one single-port-read, single-port-write synchronous memory.
//
// Command channel: a command word (i_cmd) is taken at a rising edge where start
// is high and busy is low. busy stays high while the command is worked on, so
// only one command is in flight at a time.
// Result channel: every command yields exactly one result word on o_rsp, shown
// for exactly one cycle with o_valid high. The receiver cannot stall, so it
// must take the word in that cycle. busy is already low during that cycle,
// and a new command can be accepted at its closing edge.
//
// Push, set, insert at the end, clear, error cases and unused codes finish in
// the decode state without a memory read; pop, get, front and back wait for one
// read; swap reads both entries and then writes them back. Insert below the end,
// erase and find step through the store, the memory moving or comparing one
// entry per cycle, so their time grows with the number of entries they pass.
//
// Reset clears the count, so the store reads as empty; memory contents are not
// cleared and no clearing pass is needed.
module bounded_vector_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  bve_pkg::t_cmd_word     i_cmd,
    output logic                   busy,
    output logic                   o_valid,
    output bve_pkg::t_rsp_word     o_rsp
);

    // Memory request from the sequencer, and the registered read word back.
    bve_pkg::t_mem_req             mem_req;
    logic [bve_pkg::DATA_W-1:0]    mem_rdata;

    // The sequencer owns the count, the command register and the result word.
    bve_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_rdata (mem_rdata),
        .o_mem   (mem_req),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // The element store. Read data is registered and returned in the cycle after the address is given.
    // The sequencer never reads and writes the same entry in one cycle.
    bve_ram #(
        .DATA_W (bve_pkg::DATA_W),
        .ADDR_W (bve_pkg::ADDR_W),
        .WORDS  (bve_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: design/bve_checker.sv
module bve_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input bve_pkg::t_rsp_word o_rsp
);

    // An accepted command always keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a command");

    // A result word is never followed by another in the next cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result words in consecutive cycles");

    // The result appears once the command has finished.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // The empty flag agrees with the count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.is_empty == (o_rsp.element_total == 16'd0)))
        else $error("empty flag disagrees with element count");

    // A failed command reads no word.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != bve_pkg::ST_OK)) |-> (o_rsp.word_out == '0))
        else $error("word returned with an error status");

endmodule

bind bounded_vector_engine bve_checker u_bve_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
